// ===== rtl/nrmc_pkg.sv =====
// Shared constants, types and helper functions for the NMEA RMC position parser.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package nrmc_pkg;

  // Number format: unsigned value scaled by ten to the power FRAC_DIGITS
  localparam int FRAC_DIGITS = 5;
  localparam int VALUE_BITS  = 34;
  localparam int SUM_W       = VALUE_BITS + 4;
  localparam int POW_W       = 27;
  localparam int PROD_W      = POW_W + 4;
  localparam int CNT_W       = 4;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [CNT_W-1:0] FRAC_CNT = CNT_W'(FRAC_DIGITS);

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Running state of one number field
  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic [CNT_W-1:0]      frac_cnt;
    logic                  point_seen;
    logic                  stopped;
  } num_state_t;

  // One result beat
  typedef struct packed {
    logic                  valid_res;
    logic [VALUE_BITS-1:0] latitude_value;
    logic [VALUE_BITS-1:0] longitude_value;
  } res_t;

  // Powers of ten from one up to ten to the eighth; zero for any larger k
  function automatic logic [POW_W-1:0] pow_ten(input logic [CNT_W-1:0] k);
    logic [POW_W-1:0] p;
    case (k)
      4'd0:    p = POW_W'(1);
      4'd1:    p = POW_W'(10);
      4'd2:    p = POW_W'(100);
      4'd3:    p = POW_W'(1000);
      4'd4:    p = POW_W'(10000);
      4'd5:    p = POW_W'(100000);
      4'd6:    p = POW_W'(1000000);
      4'd7:    p = POW_W'(10000000);
      4'd8:    p = POW_W'(100000000);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/nrmc_if.sv =====
// Handshake channels of the NMEA RMC position parser: received bytes and results.
// Depends on nrmc_pkg for the value width.
interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_res_if;
  logic                           valid;
  logic                           ready;
  logic                           valid_res;
  logic [nrmc_pkg::VALUE_BITS-1:0] latitude_value;
  logic [nrmc_pkg::VALUE_BITS-1:0] longitude_value;

  modport source (output valid, output valid_res, output latitude_value,
                  output longitude_value, input ready);
  modport sink (input valid, input valid_res, input latitude_value,
                input longitude_value, output ready);
endinterface

// ===== rtl/nrmc_num_feed.sv =====
// Next state of the decimal number accumulator for one received character.
// Depends on nrmc_pkg (num_state_t, pow_ten, character codes).
module nrmc_num_feed (
  input  nrmc_pkg::num_state_t cur,
  input  logic [7:0]           rx_byte,
  output nrmc_pkg::num_state_t nxt
);

  logic                             is_digit;
  logic [3:0]                       digit;
  logic [nrmc_pkg::CNT_W-1:0]       cnt_inc;
  logic [nrmc_pkg::CNT_W-1:0]       pow_sel;
  logic [nrmc_pkg::PROD_W-1:0]      addend;
  logic [nrmc_pkg::SUM_W-1:0]       base;
  logic [nrmc_pkg::SUM_W-1:0]       sum;
  logic [nrmc_pkg::VALUE_BITS-1:0]  sat;

  // Decode the character and pick the scale of this digit
  always_comb begin
    is_digit = (rx_byte >= nrmc_pkg::CH_ZERO) && (rx_byte <= nrmc_pkg::CH_NINE);
    digit    = rx_byte[3:0];
    cnt_inc  = (cur.frac_cnt < nrmc_pkg::CNT_MAX) ? cur.frac_cnt + 1'b1 : cur.frac_cnt;
    pow_sel  = cur.point_seen ? (nrmc_pkg::FRAC_CNT - cnt_inc) : nrmc_pkg::FRAC_CNT;
    addend   = nrmc_pkg::PROD_W'(digit) * nrmc_pkg::PROD_W'(nrmc_pkg::pow_ten(pow_sel));
    base     = cur.point_seen ? nrmc_pkg::SUM_W'(cur.acc)
                              : (nrmc_pkg::SUM_W'(cur.acc) << 3) + (nrmc_pkg::SUM_W'(cur.acc) << 1);
    sum      = base + nrmc_pkg::SUM_W'(addend);
    // Saturate at the top of the value range
    sat      = (sum[nrmc_pkg::SUM_W-1:nrmc_pkg::VALUE_BITS] != '0) ? '1
                                                               : sum[nrmc_pkg::VALUE_BITS-1:0];
  end

  // Advance the number state
  always_comb begin
    nxt = cur;
    if (!cur.stopped) begin
      if (is_digit) begin
        if (!cur.point_seen) begin
          nxt.acc = sat;
        end else begin
          nxt.frac_cnt = cnt_inc;
          if (cnt_inc <= nrmc_pkg::FRAC_CNT) begin
            nxt.acc = sat;
          end
        end
      end else if (rx_byte == nrmc_pkg::CH_POINT && !cur.point_seen) begin
        nxt.point_seen = 1'b1;
      end else begin
        nxt.stopped = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/nrmc_parse_core.sv =====
// Sentence sequencer: header match, field skipping, number capture and result register.
// Depends on nrmc_pkg and nrmc_num_feed.
module nrmc_parse_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 out_ready,
  output logic                 step,
  output logic                 out_valid,
  output nrmc_pkg::res_t       res
);

  typedef enum logic [4:0] {
    P_IDLE, P_G, P_P, P_R, P_M, P_C, P_COMMA1, P_TIME_FIRST, P_TIME_SKIP,
    P_STATUS, P_COMMA2, P_LAT, P_SKIP1, P_SKIP2, P_LON
  } pos_t;

  pos_t                            pos, pos_next;
  nrmc_pkg::num_state_t            num, num_next, num_fed;
  logic [nrmc_pkg::VALUE_BITS-1:0] held_lat, held_lat_next;
  logic                            emit, emit_ok;
  logic                            field_end;

  localparam nrmc_pkg::num_state_t NUM_CLEAR = '0;

  nrmc_num_feed u_num_feed (
    .cur     (num),
    .rx_byte (in_byte),
    .nxt     (num_fed)
  );

  // Take a byte whenever the result register has room for its outcome
  assign step      = in_valid && (!out_valid || out_ready);
  assign field_end = (in_byte == nrmc_pkg::CH_COMMA) || (in_byte == nrmc_pkg::CH_NUL);

  // Work out the next parse position and whether a result leaves
  always_comb begin
    pos_next      = pos;
    num_next      = num;
    held_lat_next = held_lat;
    emit          = 1'b0;
    emit_ok       = 1'b0;
    case (pos)
      P_G:          if (in_byte == nrmc_pkg::CH_G) pos_next = P_P; else emit = 1'b1;
      P_P:          if (in_byte == nrmc_pkg::CH_P) pos_next = P_R; else emit = 1'b1;
      P_R:          if (in_byte == nrmc_pkg::CH_R) pos_next = P_M; else emit = 1'b1;
      P_M:          if (in_byte == nrmc_pkg::CH_M) pos_next = P_C; else emit = 1'b1;
      P_C:          if (in_byte == nrmc_pkg::CH_C) pos_next = P_COMMA1; else emit = 1'b1;
      P_COMMA1: begin
        if (in_byte == nrmc_pkg::CH_COMMA) pos_next = P_TIME_FIRST;
        else emit = 1'b1;
      end
      P_TIME_FIRST: begin
        if (in_byte == nrmc_pkg::CH_COMMA) emit = 1'b1;
        else pos_next = P_TIME_SKIP;
      end
      P_TIME_SKIP: begin
        if (in_byte == nrmc_pkg::CH_COMMA) pos_next = P_STATUS;
      end
      P_STATUS: begin
        if (in_byte == nrmc_pkg::CH_A || in_byte == nrmc_pkg::CH_V) pos_next = P_COMMA2;
        else emit = 1'b1;
      end
      P_COMMA2: begin
        if (in_byte == nrmc_pkg::CH_COMMA) begin
          num_next = NUM_CLEAR;
          pos_next = P_LAT;
        end else begin
          emit = 1'b1;
        end
      end
      P_LAT: begin
        if (field_end) begin
          held_lat_next = num.acc;
          num_next      = NUM_CLEAR;
          pos_next      = P_SKIP1;
        end else begin
          num_next = num_fed;
        end
      end
      P_SKIP1:      pos_next = P_SKIP2;
      P_SKIP2: begin
        num_next = NUM_CLEAR;
        pos_next = P_LON;
      end
      P_LON: begin
        if (field_end) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else begin
          num_next = num_fed;
        end
      end
      default: begin
        if (in_byte == nrmc_pkg::CH_DOLLAR) pos_next = P_G;
        else emit = 1'b1;
      end
    endcase
    // Any result ends the attempt
    if (emit) begin
      pos_next = P_IDLE;
      num_next = NUM_CLEAR;
    end
  end

  // Hold parse state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= P_IDLE;
      num       <= NUM_CLEAR;
      held_lat  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        pos       <= pos_next;
        num       <= num_next;
        held_lat  <= held_lat_next;
        out_valid <= emit;
        if (emit) begin
          res.valid_res       <= emit_ok;
          res.latitude_value  <= emit_ok ? held_lat : '0;
          res.longitude_value <= emit_ok ? num.acc : '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/nmea_rmc_position_parser.sv =====
// NMEA RMC position parser: one received byte per beat in, at most one result per byte.
// A result is held in the result register once the byte that completes it has passed the input register.
// Throughput: one byte per cycle, held back only while a result waits at the output.
// Reset (rst, synchronous, active high) returns to idle, awaiting a dollar sign,
// and empties the input and result registers.
// Depends on nrmc_pkg, nrmc_if and nrmc_parse_core.
module nmea_rmc_position_parser (
  input  logic              clk,
  input  logic              rst,
  nrmc_byte_if.sink         rx_in,
  nrmc_res_if.source        res_out
);

  logic           in_valid;
  logic [7:0]     in_byte;
  logic           step;
  logic           out_valid;
  nrmc_pkg::res_t res;

  // Input register: refill as the held byte is consumed
  assign rx_in.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_in.valid && rx_in.ready) begin
      in_valid <= 1'b1;
      in_byte  <= rx_in.rx_byte;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  nrmc_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .out_ready (res_out.ready),
    .step      (step),
    .out_valid (out_valid),
    .res       (res)
  );

  assign res_out.valid           = out_valid;
  assign res_out.valid_res       = res.valid_res;
  assign res_out.latitude_value  = res.latitude_value;
  assign res_out.longitude_value = res.longitude_value;

endmodule

// ===== rtl/nrmc_checker.sv =====
// Port-level checks on the NMEA RMC position parser, bound to the top level.
// Depends on nrmc_pkg for the value width.
module nrmc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            valid_res,
  input logic [nrmc_pkg::VALUE_BITS-1:0] latitude_value,
  input logic [nrmc_pkg::VALUE_BITS-1:0] longitude_value
);

  // No result is offered straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A failed attempt carries zero values
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (latitude_value == '0 && longitude_value == '0))
    else $error("failed result with non-zero values");

  // Bytes are refused only while a result is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused without output back-pressure");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(valid_res)
      && $stable(latitude_value) && $stable(longitude_value)))
    else $error("stalled result changed");

endmodule

bind nmea_rmc_position_parser nrmc_checker u_nrmc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (rx_in.ready),
  .out_valid       (res_out.valid),
  .out_ready       (res_out.ready),
  .valid_res       (res_out.valid_res),
  .latitude_value  (res_out.latitude_value),
  .longitude_value (res_out.longitude_value)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nmea_rmc_position_parser: directed sentences, then random
// well-formed, broken and noise byte streams, with every beat checked against a tracker.
// Depends on nrmc_pkg, nrmc_if and the parser RTL.
module testbench;

  // Parse positions of the sentence tracker
  typedef enum logic [4:0] {
    RMC_IDLE, RMC_G, RMC_P, RMC_R, RMC_M, RMC_C, RMC_COMMA1, RMC_TIME_FIRST,
    RMC_TIME_SKIP, RMC_STATUS, RMC_COMMA2, RMC_LAT, RMC_SKIP1, RMC_SKIP2, RMC_LON
  } rmc_pos_t;

  localparam logic [nrmc_pkg::VALUE_BITS-1:0] ACC_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nrmc_byte_if rx_if ();
  nrmc_res_if  res_if ();

  nmea_rmc_position_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_if),
    .res_out (res_if)
  );

  always #5 clk = ~clk;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  nrmc_pkg::res_t expected_fixes[$];
  logic [7:0]     burst_q[$];

  // Tracker state
  rmc_pos_t                        trk_pos;
  nrmc_pkg::num_state_t            trk_num;
  logic [nrmc_pkg::VALUE_BITS-1:0] trk_held_lat;

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // Advance one number field by one character
  function automatic nrmc_pkg::num_state_t feed_number(input nrmc_pkg::num_state_t s,
                                                       input logic [7:0] b);
    logic [63:0] sum;
    logic [63:0] d;
    if (s.stopped) return s;
    if (b >= nrmc_pkg::CH_ZERO && b <= nrmc_pkg::CH_NINE) begin
      d = 64'(b - nrmc_pkg::CH_ZERO);
      if (!s.point_seen) begin
        sum = 64'(s.acc) * 64'd10 + d * ten_to(nrmc_pkg::FRAC_DIGITS);
      end else begin
        if (s.frac_cnt != nrmc_pkg::CNT_MAX) s.frac_cnt = s.frac_cnt + 1'b1;
        // drop digits beyond the fraction length
        if (s.frac_cnt > nrmc_pkg::FRAC_CNT) return s;
        sum = 64'(s.acc) + d * ten_to(nrmc_pkg::FRAC_DIGITS - int'(s.frac_cnt));
      end
      s.acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[nrmc_pkg::VALUE_BITS-1:0];
    end else if (b == nrmc_pkg::CH_POINT && !s.point_seen) begin
      s.point_seen = 1'b1;
    end else begin
      s.stopped = 1'b1;
    end
    return s;
  endfunction

  // Follow the sentence through one accepted byte and queue any fix it completes
  task automatic track_byte(input logic [7:0] b);
    nrmc_pkg::res_t fix;
    logic           done;
    logic [7:0]     want;
    fix = '0;
    done = 1'b0;
    want = nrmc_pkg::CH_C;
    case (trk_pos)
      RMC_G, RMC_P, RMC_R, RMC_M, RMC_C: begin
        case (trk_pos)
          RMC_G:   want = nrmc_pkg::CH_G;
          RMC_P:   want = nrmc_pkg::CH_P;
          RMC_R:   want = nrmc_pkg::CH_R;
          RMC_M:   want = nrmc_pkg::CH_M;
          default: want = nrmc_pkg::CH_C;
        endcase
        if (b != want) done = 1'b1;
        else trk_pos = rmc_pos_t'(trk_pos + 5'd1);
      end
      RMC_COMMA1: begin
        if (b != nrmc_pkg::CH_COMMA) done = 1'b1;
        else trk_pos = RMC_TIME_FIRST;
      end
      RMC_TIME_FIRST: begin
        if (b == nrmc_pkg::CH_COMMA) done = 1'b1;
        else trk_pos = RMC_TIME_SKIP;
      end
      RMC_TIME_SKIP: begin
        if (b == nrmc_pkg::CH_COMMA) trk_pos = RMC_STATUS;
      end
      RMC_STATUS: begin
        if (b != nrmc_pkg::CH_A && b != nrmc_pkg::CH_V) done = 1'b1;
        else trk_pos = RMC_COMMA2;
      end
      RMC_COMMA2: begin
        if (b != nrmc_pkg::CH_COMMA) begin
          done = 1'b1;
        end else begin
          trk_num = '0;
          trk_pos = RMC_LAT;
        end
      end
      RMC_LAT: begin
        if (b == nrmc_pkg::CH_COMMA || b == nrmc_pkg::CH_NUL) begin
          trk_held_lat = trk_num.acc;
          trk_num = '0;
          trk_pos = RMC_SKIP1;
        end else begin
          trk_num = feed_number(trk_num, b);
        end
      end
      RMC_SKIP1: trk_pos = RMC_SKIP2;
      RMC_SKIP2: begin
        trk_num = '0;
        trk_pos = RMC_LON;
      end
      RMC_LON: begin
        if (b == nrmc_pkg::CH_COMMA || b == nrmc_pkg::CH_NUL) begin
          done = 1'b1;
          fix.valid_res = 1'b1;
          fix.latitude_value = trk_held_lat;
          fix.longitude_value = trk_num.acc;
        end else begin
          trk_num = feed_number(trk_num, b);
        end
      end
      default: begin
        if (b != nrmc_pkg::CH_DOLLAR) done = 1'b1;
        else trk_pos = RMC_G;
      end
    endcase
    if (done) begin
      expected_fixes.push_back(fix);
      trk_pos = RMC_IDLE;
      trk_num = '0;
    end
  endtask

  // Send one byte beat, idling first at random, then track it once accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    track_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected 0x%0h got 0x%0h", mismatch_count, field, want, got);
  endtask

  // Append random number text: mostly digits with a point, now and then a stop character
  task automatic add_number_text();
    int n_int;
    int n_frac;
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
    n_frac = $urandom_range(0, 8);
    for (int i = 0; i < n_int; i++)
      burst_q.push_back(nrmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) != 0) begin
      burst_q.push_back(nrmc_pkg::CH_POINT);
      for (int i = 0; i < n_frac; i++)
        burst_q.push_back(nrmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 3))
        0:       burst_q.push_back(nrmc_pkg::CH_POINT);
        1:       burst_q.push_back("-");
        2:       burst_q.push_back(" ");
        default: burst_q.push_back(8'($urandom_range(0, 255)));
      endcase
      for (int i = $urandom_range(0, 3); i > 0; i--)
        burst_q.push_back(nrmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    burst_q.push_back(($urandom_range(0, 3) == 0) ? nrmc_pkg::CH_NUL : nrmc_pkg::CH_COMMA);
  endtask

  // Header and idle mismatches, including a dollar sign that breaks a header
  task automatic test_header_failures();
    send_text("$X");
    send_byte(8'hFF);
    send_byte(nrmc_pkg::CH_NUL);
    send_text("$GP$G");
    send_text("$GPRMX");
  endtask

  // One clean fix, with a NUL inside the time field
  task automatic test_clean_fix();
    send_text("$GPRMC,1");
    send_byte(nrmc_pkg::CH_NUL);
    send_text(",A,4916.45,N,12311.12,");
  endtask

  // Empty latitude, arbitrary skipped bytes, saturation and excess fraction digits
  task automatic test_number_limits();
    send_text("$GPRMC,x,V,,");
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_text("99999999999.123456789");
    send_byte(nrmc_pkg::CH_NUL);
    send_text("$GPRMC,9,A,0.1234567");
    send_byte(nrmc_pkg::CH_NUL);
    send_text("S1.000019,");
  endtask

  // Second point, sign and space stop accumulation
  task automatic test_stop_characters();
    send_text("$GPRMC,1,A,12.3.4,N,-5,");
    send_text("$GPRMC,1,A, 7,N,8 6,");
  endtask

  // Empty time, bad commas and bad status
  task automatic test_field_failures();
    send_text("$GPRMC,,");
    send_text("$GPRMC;");
    send_text("$GPRMC,1,B");
    send_text("$GPRMC,1,A;");
  endtask

  // Random byte streams: mostly well-formed sentences, some broken, some noise
  task automatic test_random_sentences(input int idle, input int stall, input int n_bytes);
    int    sent;
    int    kind;
    int    cut;
    string hdr;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    hdr = "$GPRMC,";
    while (sent < n_bytes) begin
      burst_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          burst_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        for (int i = 0; i < hdr.len(); i++) burst_q.push_back(hdr[i]);
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          cut = $urandom_range(0, 255);
          burst_q.push_back((8'(cut) == nrmc_pkg::CH_COMMA) ? 8'h3A : 8'(cut));
        end
        burst_q.push_back(nrmc_pkg::CH_COMMA);
        burst_q.push_back($urandom_range(0, 1) ? nrmc_pkg::CH_A : nrmc_pkg::CH_V);
        burst_q.push_back(nrmc_pkg::CH_COMMA);
        add_number_text();
        burst_q.push_back(8'($urandom_range(0, 255)));
        burst_q.push_back(8'($urandom_range(0, 255)));
        add_number_text();
        // break two sentences in nine: corrupt a byte or cut the tail
        if (kind <= 2) begin
          cut = $urandom_range(0, burst_q.size() - 1);
          if (kind == 1) burst_q[cut] = 8'($urandom_range(0, 255));
          else while (burst_q.size() > cut) void'(burst_q.pop_back());
        end
      end
      foreach (burst_q[i]) send_byte(burst_q[i]);
      sent += burst_q.size();
    end
  endtask

  // Result side: check each beat, then stall at random
  initial begin
    nrmc_pkg::res_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (expected_fixes.size() == 0) begin
          report_mismatch("result with none expected, latitude", '0,
                          64'(res_if.latitude_value));
        end else begin
          want = expected_fixes.pop_front();
          if (res_if.valid_res !== want.valid_res)
            report_mismatch("valid_res", 64'(want.valid_res), 64'(res_if.valid_res));
          if (res_if.latitude_value !== want.latitude_value)
            report_mismatch("latitude_value", 64'(want.latitude_value),
                            64'(res_if.latitude_value));
          if (res_if.longitude_value !== want.longitude_value)
            report_mismatch("longitude_value", 64'(want.longitude_value),
                            64'(res_if.longitude_value));
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus sequence
  initial begin
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    trk_pos = RMC_IDLE;
    trk_num = '0;
    trk_held_lat = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_header_failures();
    test_clean_fix();
    test_number_limits();
    test_stop_characters();
    test_field_failures();
    test_random_sentences(0, 0, 250);
    test_random_sentences(81, 0, 250);
    test_random_sentences(0, 81, 250);
    test_random_sentences(32, 32, 260);

    rx_if.valid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
